[hw/rtl/hic_pkg.sv]
`default_nettype none

package hic_pkg;

  localparam int unsigned NumSrc  = 5;
  localparam int unsigned SrcW    = 3;
  localparam int unsigned CmdW    = 3;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned DelayW  = 2;

  localparam logic [ByteW-1:0]  FlagFill   = 8'hE0;
  localparam logic [DelayW-1:0] DelayArmed = 2'd2;
  localparam logic [DelayW-1:0] DelayOne   = 2'd1;
  localparam logic [DelayW-1:0] DelayIdle  = 2'd0;

  typedef enum logic [CmdW-1:0] {
    CmdRaise      = 3'd0,
    CmdMasterOn   = 3'd1,
    CmdMasterOff  = 3'd2,
    CmdCheck      = 3'd3,
    CmdWrFlags    = 3'd4,
    CmdWrEnables  = 3'd5,
    CmdRdFlags    = 3'd6,
    CmdRdEnables  = 3'd7
  } hic_cmd_e;

  typedef struct packed {
    logic             dispatch;
    logic [ByteW-1:0] vector;
    logic             resume;
    logic [ByteW-1:0] read_data;
  } hic_res_t;

  function automatic logic [ByteW-1:0] hic_vector(input logic [SrcW-1:0] idx);
    logic [ByteW-1:0] v;
    case (idx)
      3'd0:    v = 8'h40;
      3'd1:    v = 8'h48;
      3'd2:    v = 8'h50;
      3'd3:    v = 8'h58;
      3'd4:    v = 8'h60;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/hic_core.sv]
`default_nettype none

module hic_core
  import hic_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             step_i,
  input  wire logic [CmdW-1:0]  cmd_i,
  input  wire logic [SrcW-1:0]  source_i,
  input  wire logic [ByteW-1:0] write_data_i,
  output hic_res_t              res_o
);

  logic [NumSrc-1:0] flags_q, flags_d;
  logic [NumSrc-1:0] enables_q, enables_d;
  logic              master_q, master_d;
  logic [DelayW-1:0] delay_q, delay_d;

  hic_cmd_e          cmd;
  logic [NumSrc-1:0] flags_mid;
  logic [NumSrc-1:0] live;
  logic              check_en;
  logic              found;
  logic [SrcW-1:0]   pick;
  hic_res_t          res;

  assign cmd = hic_cmd_e'(cmd_i);

  always_comb begin
    flags_d   = flags_q;
    enables_d = enables_q;
    master_d  = master_q;
    delay_d   = delay_q;
    res       = '0;
    flags_mid = flags_q;
    check_en  = 1'b0;

    case (cmd)
      CmdRaise: begin
        if (source_i < SrcW'(NumSrc)) begin
          flags_mid = flags_q | (NumSrc'(1) << source_i);
        end
        check_en = master_q;
      end
      CmdMasterOn: begin
        master_d = 1'b1;
        delay_d  = DelayArmed;
      end
      CmdMasterOff: begin
        master_d = 1'b0;
      end
      CmdCheck: begin
        check_en = 1'b1;
      end
      CmdWrFlags: begin
        flags_mid = write_data_i[NumSrc-1:0];
        if (master_q && (write_data_i != '0)) begin
          delay_d = DelayOne;
        end
      end
      CmdWrEnables: begin
        enables_d = write_data_i[NumSrc-1:0];
      end
      CmdRdFlags: begin
        res.read_data = FlagFill | {{(ByteW-NumSrc){1'b0}}, flags_q};
      end
      CmdRdEnables: begin
        res.read_data = {{(ByteW-NumSrc){1'b0}}, enables_q};
      end
      default: begin
        res = '0;
      end
    endcase

    live    = flags_mid & enables_q;
    flags_d = flags_mid;

    // lowest enabled pending source wins
    found = 1'b0;
    pick  = '0;
    for (int k = 0; k < NumSrc; k++) begin
      if (live[k] && !found) begin
        found = 1'b1;
        pick  = SrcW'(k);
      end
    end

    if (check_en) begin
      if (delay_q == DelayArmed) begin
        delay_d = DelayOne;
      end else begin
        delay_d = DelayIdle;
        if (!master_q) begin
          res.resume = |live;
        end else if (found) begin
          flags_d[pick] = 1'b0;
          res.dispatch  = 1'b1;
          res.vector    = hic_vector(pick);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q   <= '0;
      enables_q <= '0;
      master_q  <= 1'b0;
      delay_q   <= DelayIdle;
    end else if (step_i) begin
      flags_q   <= flags_d;
      enables_q <= enables_d;
      master_q  <= master_d;
      delay_q   <= delay_d;
    end
  end

  assign res_o = res;

`ifndef SYNTHESIS
  a_delay_reachable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    delay_q != 2'd3) else $error("enable delay reached an unused value");

  a_dispatch_needs_master: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.dispatch |-> master_q) else $error("dispatch with master enable off");

  a_dispatch_xor_resume: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(res.dispatch && res.resume)) else $error("dispatch and resume together");

  a_master_on_arms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && cmd == CmdMasterOn) |=> (master_q && delay_q == DelayArmed))
    else $error("master enable did not arm delay");

  a_dispatch_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && res.dispatch) |=> !flags_q[$past(pick)])
    else $error("dispatched request not cleared");
`endif

endmodule

`default_nettype wire

[hw/rtl/hic_out_buf.sv]
`default_nettype none

module hic_out_buf
  import hic_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push_i,
  input  wire hic_res_t res_i,
  output logic          full_o,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output hic_res_t      out_res_o
);

  logic     out_valid_q, out_valid_d;
  logic     skid_valid_q, skid_valid_d;
  hic_res_t out_q, out_d;
  hic_res_t skid_q, skid_d;
  logic     out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (out_free) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_d       = res_i;
        skid_valid_d = push_i;
      end else begin
        out_d       = res_i;
        out_valid_d = push_i;
      end
    end else if (push_i) begin
      skid_d       = res_i;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q) else $error("skid holds a beat ahead of output");

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> !push_i) else $error("beat pushed into full buffer");

  a_skid_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && !out_stall_i) |=> out_valid_q)
    else $error("skid beat lost on drain");
`endif

endmodule

`default_nettype wire

[hw/rtl/handheld_interrupt_controller_top.sv]
// channel  dir  handshake                    payload
// in       in   in_valid_i / in_stall_o      cmd_i, source_i, write_data_i
// out      out  out_valid_o / out_stall_i    dispatch_o, vector_o, resume_o, read_data_o
//
// one beat accepted per cycle while in_stall_o is low; its result is registered and offered
// state updates on the accept edge, so back-to-back commands see each other at once
// a two-entry output buffer (output register plus skid) decouples the two sides
// in_stall_o rises only while both entries hold beats; it comes from a register
// reset clears flags, enables, master enable, delay and both buffer entries
`default_nettype none

module handheld_interrupt_controller_top
  import hic_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic [CmdW-1:0]  cmd_i,
  input  wire logic [SrcW-1:0]  source_i,
  input  wire logic [ByteW-1:0] write_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic                  dispatch_o,
  output logic [ByteW-1:0]      vector_o,
  output logic                  resume_o,
  output logic [ByteW-1:0]      read_data_o
);

  logic     accept;
  logic     full;
  hic_res_t res;
  hic_res_t out_res;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  hic_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (accept),
    .cmd_i        (cmd_i),
    .source_i     (source_i),
    .write_data_i (write_data_i),
    .res_o        (res)
  );

  hic_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .res_i       (res),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_res_o   (out_res)
  );

  assign dispatch_o  = out_res.dispatch;
  assign vector_o    = out_res.vector;
  assign resume_o    = out_res.resume;
  assign read_data_o = out_res.read_data;

endmodule

`default_nettype wire
